>>> sv/csbf_pkg.sv
// Shared constants and types for the cascaded smoother band filter.
`default_nettype none

package csbf_pkg;

    // Default sizes of the two smoother chains and of the stage state.
    localparam int HIGH_STAGES_DEF = 21;
    localparam int LOW_STAGES_DEF  = 13;
    localparam int STATE_BITS_DEF  = 32;

    // Samples: signed Q1.23; coefficients: unsigned Q1.24.
    localparam int SAMPLE_W   = 24;
    localparam int DATA_W     = 2 * SAMPLE_W;
    localparam int COEF_W     = 25;
    localparam int COEF_FRAC  = 24;
    localparam int SAMPLE_MAX = 8388607;
    localparam int SAMPLE_MIN = -8388608;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

    // Configuration register map.
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_COEF  = 1'b0,
        REG_HIGH_COEF = 1'b1
    } cfg_reg_t;

    // Stage coefficient c and its complement k = 1.0 - c.
    typedef struct packed {
        logic [COEF_W-1:0] c;
        logic [COEF_W-1:0] k;
    } coef_t;

endpackage

`default_nettype wire

>>> sv/csbf_cell.sv
// One two-state smoother stage of one channel, run as a five-step sequence.
`default_nettype none

module csbf_cell
    import csbf_pkg::*;
#(
    parameter int STATE_BITS = STATE_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         go,
    input  wire logic                         clear,
    input  wire coef_t                        coef,
    input  wire logic signed [STATE_BITS-1:0] x_in,
    output logic                              done,
    output logic signed [STATE_BITS-1:0]      y_out
);

    localparam int SB = STATE_BITS;
    localparam int VW = SB + 1;
    localparam int PW = VW + COEF_W + 1;
    localparam logic signed [PW-1:0]   RND    = PW'(64'd1 << (COEF_FRAC - 1));
    localparam logic signed [SB+1:0]   ST_MAX = {3'b000, {(SB - 1){1'b1}}};
    localparam logic signed [SB+1:0]   ST_MIN = {3'b111, {(SB - 1){1'b0}}};

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_MA   = 6'b000010,
        PH_MB   = 6'b000100,
        PH_MC   = 6'b001000,
        PH_MD   = 6'b010000,
        PH_ME   = 6'b100000
    } phase_t;

    // round(v * cf / 2^24), halves up
    function automatic logic signed [SB:0] mulc(input logic signed [SB:0] v,
                                                input logic [COEF_W-1:0] cf);
        logic signed [PW-1:0] prod;
        prod = PW'(v) * $signed(PW'(cf));
        prod = prod + RND;
        return prod[COEF_FRAC +: VW];
    endfunction

    function automatic logic signed [SB-1:0] sat_st(input logic signed [SB+1:0] v);
        if (v > ST_MAX) begin
            return ST_MAX[SB-1:0];
        end else if (v < ST_MIN) begin
            return ST_MIN[SB-1:0];
        end
        return v[SB-1:0];
    endfunction

    phase_t                 phase_reg, phase_next;
    logic signed [SB-1:0]   p_reg, s_reg, x_reg, y_reg;
    logic signed [SB:0]     prod1_reg, prod2_reg;

    logic signed [SB-1:0]   sum12, t_val;
    logic signed [SB:0]     op_a, op_b, mul_a, mul_b;
    logic [COEF_W-1:0]      cf_a;

    // Shared adder: slope (step B), output (step D), position (step E).
    assign sum12 = sat_st((SB + 2)'(prod1_reg) + (SB + 2)'(prod2_reg));
    assign t_val = sat_st((SB + 2)'(p_reg) + (SB + 2)'(prod1_reg));

    always_comb begin
        op_a = '0;
        cf_a = coef.k;
        op_b = '0;
        case (phase_reg)
            PH_MA: begin
                op_a = VW'(s_reg);
                op_b = VW'(x_reg) - VW'(p_reg);
            end
            PH_MB: begin
                op_a = VW'(sum12);
                cf_a = coef.c;
            end
            PH_MC: begin
                op_a = VW'(t_val);
                op_b = VW'(x_reg);
            end
            PH_MD: begin
                op_b = VW'(sum12);
            end
            default: begin
            end
        endcase
    end

    assign mul_a = mulc(op_a, cf_a);
    assign mul_b = mulc(op_b, coef.c);

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: if (go) begin
                phase_next = PH_MA;
            end
            PH_MA:   phase_next = PH_MB;
            PH_MB:   phase_next = PH_MC;
            PH_MC:   phase_next = PH_MD;
            PH_MD:   phase_next = PH_ME;
            PH_ME:   phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            p_reg     <= '0;
            s_reg     <= '0;
        end else begin
            phase_reg <= phase_next;
            if (clear) begin
                p_reg <= '0;
                s_reg <= '0;
            end else if (phase_reg == PH_MB) begin
                s_reg <= sum12;
            end else if (phase_reg == PH_ME) begin
                p_reg <= sum12;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == PH_IDLE && go) begin
            x_reg <= x_in;
        end
        if (phase_reg == PH_MA || phase_reg == PH_MB || phase_reg == PH_MC) begin
            prod1_reg <= mul_a;
        end
        if (phase_reg == PH_MA || phase_reg == PH_MC || phase_reg == PH_MD) begin
            prod2_reg <= mul_b;
        end
        if (phase_reg == PH_MD) begin
            y_reg <= sum12;
        end
    end

    assign done  = (phase_reg == PH_ME);
    assign y_out = y_reg;

endmodule

`default_nettype wire

>>> sv/csbf_div.sv
// Rounded division of a stage output by the highpass stage count, four steps.
`default_nettype none

module csbf_div
    import csbf_pkg::*;
#(
    parameter int STATE_BITS = STATE_BITS_DEF,
    parameter int DIVISOR    = HIGH_STAGES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic signed [STATE_BITS-1:0] y_in,
    output logic                              ready,
    output logic                              q_valid,
    output logic                              q_neg,
    output logic [STATE_BITS-1:0]             q_mag
);

    localparam int SB    = STATE_BITS;
    localparam int STEPS = 4;
    localparam int BPS   = (SB + STEPS - 1) / STEPS;
    localparam int DW    = BPS * STEPS;
    localparam int RW    = $clog2(DIVISOR + 1);
    localparam int CW    = $clog2(STEPS + 1);
    localparam int HALF  = DIVISOR / 2;

    logic               busy_reg;
    logic [CW-1:0]      cnt_reg;
    logic [DW-1:0]      dvd_reg, dvd_step;
    logic [RW-1:0]      rem_reg, rem_step;
    logic               neg_reg;
    logic signed [SB:0] y_ext, y_abs, y_biased;

    // |y| + DIVISOR/2; below 2^SB for any state value
    assign y_ext    = (SB + 1)'(y_in);
    assign y_abs    = y_in[SB-1] ? -y_ext : y_ext;
    assign y_biased = y_abs + (SB + 1)'(HALF);

    // Restoring long division, BPS quotient bits per cycle
    always_comb begin
        logic [DW-1:0] d;
        logic [RW-1:0] r;
        logic [RW:0]   trial;
        d = dvd_reg;
        r = rem_reg;
        for (int b = 0; b < BPS; b++) begin
            trial = {r, d[DW-1]};
            if (trial >= (RW + 1)'(DIVISOR)) begin
                r = RW'(trial - (RW + 1)'(DIVISOR));
                d = {d[DW-2:0], 1'b1};
            end else begin
                r = trial[RW-1:0];
                d = {d[DW-2:0], 1'b0};
            end
        end
        dvd_step = d;
        rem_step = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(STEPS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CW'(1);
        end else begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= DW'(y_biased[SB-1:0]);
            rem_reg <= '0;
            neg_reg <= y_in[SB-1];
        end else if (cnt_reg != '0) begin
            dvd_reg <= dvd_step;
            rem_reg <= rem_step;
        end
    end

    assign ready   = !busy_reg || (cnt_reg == '0);
    assign q_valid = busy_reg && (cnt_reg == '0);
    assign q_neg   = neg_reg;
    assign q_mag   = dvd_reg[SB-1:0];

endmodule

`default_nettype wire

>>> sv/cascaded_smoother_band_filter_unit.sv
// Top level of the stereo cascaded smoother band filter.
//
// Takes one stereo pair (Q1.23) and returns one filtered, saturated pair.
// The highpass is a row of HIGH_STAGES smoother cells per channel; each cell
// output, divided by HIGH_STAGES with rounding, is subtracted from the running
// signal. The lowpass is a row of LOW_STAGES cells per channel in series. A cell
// runs its stage as four dependent multiply steps, then the position update,
// and hands its output to the next cell, which then starts; each highpass cell
// output also passes through the rounded division. A bypassed section's cells
// do not run. A section is bypassed by high_coef == 0 or low_coef >= 1.0; its
// first bypassed item clears that section's cell state. Items are taken one at
// a time; the next item is accepted while the previous result still waits on
// the master side. Coefficients must be written by the user through the plain
// write port while the block idles; the block itself does not enforce this.
`default_nettype none

module cascaded_smoother_band_filter_unit
    import csbf_pkg::*;
#(
    parameter int HIGH_STAGES = HIGH_STAGES_DEF,
    parameter int LOW_STAGES  = LOW_STAGES_DEF,
    parameter int STATE_BITS  = STATE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]    cfg_wdata,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_W-1:0]    s_tdata,  // [23:0] left_in, [47:24] right_in
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [DATA_W-1:0]         m_tdata   // [23:0] left_out, [47:24] right_out
);

    localparam int SB = STATE_BITS;
    localparam int HW = $clog2(HIGH_STAGES + 1);
    localparam logic signed [SB+1:0] ST_MAX  = {3'b000, {(SB - 1){1'b1}}};
    localparam logic signed [SB+1:0] ST_MIN  = {3'b111, {(SB - 1){1'b0}}};
    localparam logic signed [SB-1:0] OUT_MAX = SB'(SAMPLE_MAX);
    localparam logic signed [SB-1:0] OUT_MIN = SB'(SAMPLE_MIN);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HP   = 5'b00010,
        ST_LPS  = 5'b00100,
        ST_LPW  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    function automatic logic signed [SB-1:0] sat_st(input logic signed [SB+1:0] v);
        if (v > ST_MAX) begin
            return ST_MAX[SB-1:0];
        end else if (v < ST_MIN) begin
            return ST_MIN[SB-1:0];
        end
        return v[SB-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] sat_out(input logic signed [SB-1:0] v);
        if (v > OUT_MAX) begin
            return OUT_MAX[SAMPLE_W-1:0];
        end else if (v < OUT_MIN) begin
            return OUT_MIN[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [COEF_W-1:0] low_coef_reg, high_coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_coef_reg  <= COEF_ONE;
            high_coef_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LOW_COEF:  low_coef_reg  <= cfg_wdata;
                REG_HIGH_COEF: high_coef_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Values above 1.0 act as 1.0
    logic [COEF_W-1:0] hc_clamp, lc_clamp;
    assign hc_clamp = (high_coef_reg > COEF_ONE) ? COEF_ONE : high_coef_reg;
    assign lc_clamp = (low_coef_reg  > COEF_ONE) ? COEF_ONE : low_coef_reg;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    state_t              state_reg;
    logic                hp_go_reg, lp_go_reg, hp_clear_reg, lp_clear_reg;
    logic                hp_byp_reg, lp_byp_reg;
    logic [HW-1:0]       hp_cnt_reg;
    coef_t               hp_coef_reg, lp_coef_reg;
    logic signed [SB-1:0] acc_l_reg, acc_r_reg;
    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg;

    logic                in_take, out_load, lp_on;
    logic                q_valid_l, q_valid_r, q_neg_l, q_neg_r;
    logic [SB-1:0]       q_mag_l, q_mag_r;
    logic signed [SB+1:0] q_l, q_r;
    logic                lp_last_done;
    logic signed [SB-1:0] lp_last_l, lp_last_r, res_l, res_r;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign lp_on    = (lp_coef_reg.k != '0);
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // signed quotient for the running highpass sum
    assign q_l = q_neg_l ? -(SB + 2)'(q_mag_l) : (SB + 2)'(q_mag_l);
    assign q_r = q_neg_r ? -(SB + 2)'(q_mag_r) : (SB + 2)'(q_mag_r);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            hp_go_reg    <= 1'b0;
            lp_go_reg    <= 1'b0;
            hp_clear_reg <= 1'b0;
            lp_clear_reg <= 1'b0;
            hp_byp_reg   <= 1'b0;
            lp_byp_reg   <= 1'b0;
            hp_cnt_reg   <= '0;
        end else begin
            // one-cycle start and clear pulses for the cell rows
            hp_go_reg    <= in_take && (hc_clamp != '0);
            hp_clear_reg <= in_take && (hc_clamp == '0) && !hp_byp_reg;
            lp_go_reg    <= (state_reg == ST_LPS) && lp_on;
            lp_clear_reg <= (state_reg == ST_LPS) && !lp_on && !lp_byp_reg;
            case (state_reg)
                ST_IDLE: if (in_take) begin
                    hp_cnt_reg <= '0;
                    if (hc_clamp != '0) begin
                        hp_byp_reg <= 1'b0;
                        state_reg  <= ST_HP;
                    end else begin
                        // first bypassed item wipes the highpass cells
                        hp_byp_reg <= 1'b1;
                        state_reg  <= ST_LPS;
                    end
                end
                ST_HP: if (q_valid_l) begin
                    hp_cnt_reg <= hp_cnt_reg + HW'(1);
                    if (hp_cnt_reg == HW'(HIGH_STAGES - 1)) begin
                        state_reg <= ST_LPS;
                    end
                end
                ST_LPS: begin
                    lp_byp_reg <= !lp_on;
                    state_reg  <= lp_on ? ST_LPW : ST_OUT;
                end
                // lowpass row finished: result ready for the output register
                ST_LPW: if (lp_last_done) begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: if (out_load) begin
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Running signal per channel: loaded from the input item, reduced by each
    // divided highpass output.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            acc_l_reg   <= SB'(signed'(s_tdata[SAMPLE_W-1:0]));
            acc_r_reg   <= SB'(signed'(s_tdata[DATA_W-1:SAMPLE_W]));
            hp_coef_reg <= '{c: hc_clamp, k: COEF_ONE - hc_clamp};
            lp_coef_reg <= '{c: lc_clamp, k: COEF_ONE - lc_clamp};
        end else begin
            if (q_valid_l) begin
                acc_l_reg <= sat_st((SB + 2)'(acc_l_reg) - q_l);
            end
            if (q_valid_r) begin
                acc_r_reg <= sat_st((SB + 2)'(acc_r_reg) - q_r);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    assign res_l = lp_on ? lp_last_l : acc_l_reg;
    assign res_r = lp_on ? lp_last_r : acc_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {sat_out(res_r), sat_out(res_l)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------------
    // Highpass rows: cell i feeds cell i+1; the first cell sees the input item
    // ---------------------------------------------------------------------
    logic [HIGH_STAGES-1:0] hp_done_l, hp_done_r;
    logic signed [SB-1:0]   hp_y_l [HIGH_STAGES];
    logic signed [SB-1:0]   hp_y_r [HIGH_STAGES];

    for (genvar i = 0; i < HIGH_STAGES; i++) begin : g_hp
        logic                 go_l, go_r;
        logic signed [SB-1:0] x_l, x_r;
        if (i == 0) begin : g_head
            assign go_l = hp_go_reg;
            assign go_r = hp_go_reg;
            assign x_l  = acc_l_reg;
            assign x_r  = acc_r_reg;
        end else begin : g_link
            assign go_l = hp_done_l[i-1];
            assign go_r = hp_done_r[i-1];
            assign x_l  = hp_y_l[i-1];
            assign x_r  = hp_y_r[i-1];
        end
        csbf_cell #(.STATE_BITS(SB)) u_cell_l (
            .aclk(aclk), .aresetn(aresetn), .go(go_l), .clear(hp_clear_reg),
            .coef(hp_coef_reg), .x_in(x_l), .done(hp_done_l[i]), .y_out(hp_y_l[i])
        );
        csbf_cell #(.STATE_BITS(SB)) u_cell_r (
            .aclk(aclk), .aresetn(aresetn), .go(go_r), .clear(hp_clear_reg),
            .coef(hp_coef_reg), .x_in(x_r), .done(hp_done_r[i]), .y_out(hp_y_r[i])
        );
    end

    // The cell that just finished drives the divider (at most one at a time)
    logic                 div_start_l, div_start_r, div_ready_l, div_ready_r;
    logic signed [SB-1:0] div_y_l, div_y_r;

    assign div_start_l = |hp_done_l;
    assign div_start_r = |hp_done_r;

    always_comb begin
        div_y_l = '0;
        div_y_r = '0;
        for (int i = 0; i < HIGH_STAGES; i++) begin
            if (hp_done_l[i]) begin
                div_y_l = div_y_l | hp_y_l[i];
            end
            if (hp_done_r[i]) begin
                div_y_r = div_y_r | hp_y_r[i];
            end
        end
    end

    csbf_div #(.STATE_BITS(SB), .DIVISOR(HIGH_STAGES)) u_div_l (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_l), .y_in(div_y_l),
        .ready(div_ready_l), .q_valid(q_valid_l), .q_neg(q_neg_l), .q_mag(q_mag_l)
    );

    csbf_div #(.STATE_BITS(SB), .DIVISOR(HIGH_STAGES)) u_div_r (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_r), .y_in(div_y_r),
        .ready(div_ready_r), .q_valid(q_valid_r), .q_neg(q_neg_r), .q_mag(q_mag_r)
    );

    // ---------------------------------------------------------------------
    // Lowpass rows: the first cell sees the highpass result
    // ---------------------------------------------------------------------
    logic [LOW_STAGES-1:0] lp_done_l, lp_done_r;
    logic signed [SB-1:0]  lp_y_l [LOW_STAGES];
    logic signed [SB-1:0]  lp_y_r [LOW_STAGES];

    for (genvar i = 0; i < LOW_STAGES; i++) begin : g_lp
        logic                 go_l, go_r;
        logic signed [SB-1:0] x_l, x_r;
        if (i == 0) begin : g_head
            assign go_l = lp_go_reg;
            assign go_r = lp_go_reg;
            assign x_l  = acc_l_reg;
            assign x_r  = acc_r_reg;
        end else begin : g_link
            assign go_l = lp_done_l[i-1];
            assign go_r = lp_done_r[i-1];
            assign x_l  = lp_y_l[i-1];
            assign x_r  = lp_y_r[i-1];
        end
        csbf_cell #(.STATE_BITS(SB)) u_cell_l (
            .aclk(aclk), .aresetn(aresetn), .go(go_l), .clear(lp_clear_reg),
            .coef(lp_coef_reg), .x_in(x_l), .done(lp_done_l[i]), .y_out(lp_y_l[i])
        );
        csbf_cell #(.STATE_BITS(SB)) u_cell_r (
            .aclk(aclk), .aresetn(aresetn), .go(go_r), .clear(lp_clear_reg),
            .coef(lp_coef_reg), .x_in(x_r), .done(lp_done_r[i]), .y_out(lp_y_r[i])
        );
    end

    assign lp_last_done = lp_done_l[LOW_STAGES-1] && lp_done_r[LOW_STAGES-1];
    assign lp_last_l    = lp_y_l[LOW_STAGES-1];
    assign lp_last_r    = lp_y_r[LOW_STAGES-1];

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // A highpass cell never hands over while its divider is still working.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_start_l |-> div_ready_l) and (div_start_r |-> div_ready_r))
        else $error("highpass divider overrun");

    // Left and right rows run in lockstep.
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid_l == q_valid_r) && (hp_done_l == hp_done_r) && (lp_done_l == lp_done_r))
        else $error("left and right channels out of step");

    // A finished item reaches the output register and frees the input side.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && (state_reg == ST_IDLE))
        else $error("result not loaded into the output register");

endmodule

`default_nettype wire
